@@ hdl/b32d_pkg.sv @@
// Shared types, constants and decode functions for the base32 decoder.
package b32d_pkg;

	// Field and storage widths
	localparam int unsigned IDX_W    = 21;
	localparam int unsigned GROUP_W  = 40;
	localparam int unsigned CFG_AW   = 3;
	localparam int unsigned CFG_DW   = 32;
	localparam longint unsigned MAX_TEXT_CHARS_DEF = 64'd1048576;

	// Character constants
	localparam logic [7:0] PAD_CHAR  = 8'h3D;
	localparam logic [7:0] ASCII_TOP = 8'h7F;

	// Register index of the alphabet select
	localparam logic REG_HEX_MODE = 1'b0;

	typedef enum logic [2:0] {
		ERR_OK           = 3'd0,
		ERR_INVALID_CHAR = 3'd1,
		ERR_DATA_AFTER   = 3'd2,
		ERR_PAD_NOT_LAST = 3'd3,
		ERR_BAD_SHAPE    = 3'd4,
		ERR_PAD_BITS     = 3'd5,
		ERR_PAD_SHORT    = 3'd6,
		ERR_LENGTH       = 3'd7
	} err_code_t;

	typedef struct packed {
		logic              valid;
		err_code_t         code;
		logic [IDX_W-1:0]  index;
	} offence_t;

	// Result bundle of one character: up to five bytes, then maybe a status
	typedef struct packed {
		logic [2:0]         nbytes;
		logic               status;
		err_code_t          code;
		logic [IDX_W-1:0]   index;
		logic [GROUP_W-1:0] word;
	} bundle_t;

	typedef struct packed {
		logic       ok;
		logic [4:0] val;
	} char_val_t;

	typedef struct packed {
		logic       ok;
		logic [2:0] nbytes;
		logic [3:0] mask;
	} shape_t;

	// Value of a character in the selected alphabet
	function automatic char_val_t char_value(input logic [7:0] c, input logic hex);
		char_val_t r;
		r = '{ok: 1'b0, val: 5'd0};
		if (c <= ASCII_TOP) begin
			if (hex) begin
				if (c >= 8'h30 && c <= 8'h39) begin
					r = '{ok: 1'b1, val: 5'(c - 8'h30)};
				end else if (c >= 8'h41 && c <= 8'h56) begin
					r = '{ok: 1'b1, val: 5'(c - 8'h41 + 8'd10)};
				end
			end else begin
				if (c >= 8'h41 && c <= 8'h5A) begin
					r = '{ok: 1'b1, val: 5'(c - 8'h41)};
				end else if (c >= 8'h32 && c <= 8'h37) begin
					r = '{ok: 1'b1, val: 5'(c - 8'h32 + 8'd26)};
				end
			end
		end
		return r;
	endfunction

	// Byte count and low pad-bit mask of a padded group by its data count
	function automatic shape_t group_shape(input logic [2:0] dc);
		shape_t r;
		case (dc)
			3'd2: r = '{ok: 1'b1, nbytes: 3'd1, mask: 4'h3};
			3'd4: r = '{ok: 1'b1, nbytes: 3'd2, mask: 4'hF};
			3'd5: r = '{ok: 1'b1, nbytes: 3'd3, mask: 4'h1};
			3'd7: r = '{ok: 1'b1, nbytes: 3'd4, mask: 4'h7};
			default: r = '{ok: 1'b0, nbytes: 3'd0, mask: 4'h0};
		endcase
		return r;
	endfunction

endpackage

@@ hdl/b32d_cfg.sv @@
// APB-style configuration register holding the alphabet select.
module b32d_cfg
	import b32d_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	output logic              hex_mode
);

	logic hex_mode_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_HEX_MODE);

	// Write the alphabet select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_mode_q <= 1'b0;
		end else if (wr_en) begin
			hex_mode_q <= pwdata[0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_HEX_MODE) begin
			prdata[0] = hex_mode_q;
		end
	end

	assign hex_mode = hex_mode_q;

endmodule

@@ hdl/b32d_decode.sv @@
// Input register, group state and per-character decode into a result bundle.
module b32d_decode
	import b32d_pkg::*;
#(
	parameter longint unsigned MAX_TEXT_CHARS = MAX_TEXT_CHARS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       hex_mode,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	input  logic       emit_ready,
	output logic       push,
	output bundle_t    bundle
);

	localparam int unsigned POS_W = $clog2(MAX_TEXT_CHARS + 64'd1);
	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_TEXT_CHARS);
	localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_TEXT_CHARS);

	// Input stage
	logic       vld_s1;
	logic [7:0] char_s1;
	logic       end_s1;

	// Group and text state
	logic [GROUP_W-1:0] gbits_q, gbits_n;
	logic [2:0]         gpos_q, gpos_n;
	logic               pad_seen_q, pad_seen_n;
	logic [2:0]         pad_slot_q, pad_slot_n;
	logic [POS_W-1:0]   tpos_q, tpos_n;
	offence_t           full_q, full_n;
	offence_t           short_q, short_n;
	offence_t           lat_q, lat_n;

	logic               has_items;
	logic               adv;
	logic               in_xfer;
	char_val_t          cv;
	shape_t             shp;
	logic               group_done;
	logic [IDX_W-1:0]   idx;
	logic [IDX_W-1:0]   pad_at_idx;
	logic [GROUP_W-1:0] padded_word;
	bundle_t            bnd;

	assign cv  = char_value(char_s1, hex_mode);
	assign idx = IDX_W'(tpos_q);

	// Decode one character against the current group
	always_comb begin
		gbits_n     = gbits_q;
		gpos_n      = gpos_q;
		pad_seen_n  = pad_seen_q;
		pad_slot_n  = pad_slot_q;
		tpos_n      = tpos_q;
		full_n      = full_q;
		short_n     = short_q;
		lat_n       = lat_q;
		group_done  = 1'b0;
		pad_at_idx  = '0;
		shp         = group_shape(3'd0);
		padded_word = '0;
		bnd         = '{nbytes: 3'd0, status: 1'b0, code: ERR_OK, index: '0, word: '0};

		if (!lat_q.valid) begin
			if (tpos_q >= MAX_POS) begin
				lat_n = '{valid: 1'b1, code: ERR_LENGTH, index: MAX_IDX};
			end else begin
				tpos_n = tpos_q + POS_W'(1);
				if (char_s1 == PAD_CHAR) begin
					if (!pad_seen_q) begin
						pad_seen_n = 1'b1;
						pad_slot_n = gpos_q;
					end
					if (!short_q.valid) begin
						short_n = '{valid: 1'b1, code: ERR_PAD_SHORT, index: idx};
					end
				end else if (!cv.ok) begin
					if (!full_q.valid) begin
						full_n = '{valid: 1'b1, code: ERR_INVALID_CHAR, index: idx};
					end
					if (!short_q.valid) begin
						short_n = '{valid: 1'b1, code: ERR_INVALID_CHAR, index: idx};
					end
				end else if (pad_seen_q) begin
					if (!full_q.valid) begin
						full_n = '{valid: 1'b1, code: ERR_DATA_AFTER, index: idx};
					end
				end else begin
					gbits_n = {gbits_q[GROUP_W-6:0], cv.val};
				end

				if (gpos_q == 3'd7) begin
					group_done = 1'b1;
					pad_at_idx = idx - IDX_W'(7) + IDX_W'(pad_slot_n);
					shp        = group_shape(pad_slot_n);
					// Left-align the data bits of a padded group
					case (pad_slot_n)
						3'd2:    padded_word = {gbits_n[9:0], 30'd0};
						3'd4:    padded_word = {gbits_n[19:0], 20'd0};
						3'd5:    padded_word = {gbits_n[24:0], 15'd0};
						3'd7:    padded_word = {gbits_n[34:0], 5'd0};
						default: padded_word = '0;
					endcase
					if (full_n.valid) begin
						lat_n = full_n;
					end else if (!pad_seen_n) begin
						bnd.nbytes = 3'd5;
						bnd.word   = gbits_n;
					end else if (!end_s1) begin
						lat_n = '{valid: 1'b1, code: ERR_PAD_NOT_LAST, index: pad_at_idx};
					end else if (!shp.ok) begin
						lat_n = '{valid: 1'b1, code: ERR_BAD_SHAPE, index: pad_at_idx};
					end else if ((gbits_n[3:0] & shp.mask) != 4'h0) begin
						lat_n = '{valid: 1'b1, code: ERR_PAD_BITS,
							index: pad_at_idx - IDX_W'(1)};
					end else begin
						bnd.nbytes = shp.nbytes;
						bnd.word   = padded_word;
					end
					gpos_n        = 3'd0;
					pad_seen_n    = 1'b0;
					full_n.valid  = 1'b0;
					short_n.valid = 1'b0;
				end else begin
					gpos_n = gpos_q + 3'd1;
				end

				if (end_s1 && !group_done) begin
					if (short_n.valid) begin
						lat_n = short_n;
					end else begin
						lat_n = '{valid: 1'b1, code: ERR_LENGTH, index: idx + IDX_W'(1)};
					end
				end
			end
		end

		// End mark: report status and restart for the next text
		if (end_s1) begin
			bnd.status = 1'b1;
			if (lat_n.valid) begin
				bnd.code  = lat_n.code;
				bnd.index = lat_n.index;
			end
			tpos_n        = '0;
			lat_n.valid   = 1'b0;
			gpos_n        = 3'd0;
			pad_seen_n    = 1'b0;
			full_n.valid  = 1'b0;
			short_n.valid = 1'b0;
		end
	end

	// Advance when the bundle is empty or the emitter can take it
	assign has_items = (bnd.nbytes != 3'd0) || bnd.status;
	assign adv       = vld_s1 && (!has_items || emit_ready);
	assign in_stall  = vld_s1 && !adv;
	assign in_xfer   = in_valid && !in_stall;
	assign push      = adv && has_items;
	assign bundle    = bnd;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_xfer) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			char_s1 <= char_code;
			end_s1  <= end_of_text;
		end
	end

	// Update decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpos_q     <= 3'd0;
			pad_seen_q <= 1'b0;
			pad_slot_q <= 3'd0;
			tpos_q     <= '0;
			full_q     <= '{valid: 1'b0, code: ERR_OK, index: '0};
			short_q    <= '{valid: 1'b0, code: ERR_OK, index: '0};
			lat_q      <= '{valid: 1'b0, code: ERR_OK, index: '0};
		end else if (adv) begin
			gpos_q     <= gpos_n;
			pad_seen_q <= pad_seen_n;
			pad_slot_q <= pad_slot_n;
			tpos_q     <= tpos_n;
			full_q     <= full_n;
			short_q    <= short_n;
			lat_q      <= lat_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gbits_q <= gbits_n;
		end
	end

endmodule

@@ hdl/b32d_emit.sv @@
// Result register that hands a bundle out one item per transfer.
module b32d_emit
	import b32d_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bundle_t          bundle,
	output logic             emit_ready,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       data_byte,
	output logic             byte_valid,
	output logic             done_res,
	output logic [2:0]       error_code,
	output logic [IDX_W-1:0] error_index
);

	logic       busy_s2;
	logic [2:0] ptr_s2;
	bundle_t    bnd_s2;
	logic [2:0] items;
	logic       last;
	logic       out_xfer;
	logic       is_byte;

	assign items      = bnd_s2.nbytes + {2'b00, bnd_s2.status};
	assign last       = (ptr_s2 + 3'd1) == items;
	assign out_valid  = busy_s2;
	assign out_xfer   = busy_s2 && !out_stall;
	assign emit_ready = !busy_s2 || (out_xfer && last);

	// Load a new bundle, step through its items, free on the last transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s2 <= 1'b0;
			ptr_s2  <= 3'd0;
		end else if (push) begin
			busy_s2 <= 1'b1;
			ptr_s2  <= 3'd0;
		end else if (out_xfer && last) begin
			busy_s2 <= 1'b0;
			ptr_s2  <= 3'd0;
		end else if (out_xfer) begin
			ptr_s2 <= ptr_s2 + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			bnd_s2 <= bundle;
		end
	end

	// Select the current item
	assign is_byte = ptr_s2 < bnd_s2.nbytes;

	always_comb begin
		data_byte = 8'd0;
		if (is_byte) begin
			case (ptr_s2)
				3'd0:    data_byte = bnd_s2.word[39:32];
				3'd1:    data_byte = bnd_s2.word[31:24];
				3'd2:    data_byte = bnd_s2.word[23:16];
				3'd3:    data_byte = bnd_s2.word[15:8];
				3'd4:    data_byte = bnd_s2.word[7:0];
				default: data_byte = 8'd0;
			endcase
		end
	end

	assign byte_valid  = is_byte;
	assign done_res    = !is_byte;
	assign error_code  = is_byte ? ERR_OK : bnd_s2.code;
	assign error_index = is_byte ? '0 : bnd_s2.index;

endmodule

@@ hdl/base32_strict_decoder_core.sv @@
// Top level of the strict base32 decoder: configuration, decode and result stages.
//
// Feed text one character per transfer on char_code/end_of_text (in_valid,
// in_stall); end_of_text marks the last character. Results leave on the
// output channel (out_valid, out_stall): data bytes with byte_valid high,
// and after each end mark one status item with done_res high, carrying
// error_code and error_index. On an error status the consumer drops the
// bytes already received for that text.
// The hex_mode register (APB, byte address 0) picks the standard or the
// hex alphabet; write it only between texts.
// An accepted character is registered in the input stage and decoded
// there; its results are registered in the result stage and shown from it.
// Throughput: one character per cycle while in_stall is low. A character
// that yields results keeps the result stage until all its items (up to
// six) have been transferred; a following character with results of its own
// waits in the input stage meanwhile, characters without results pass on.
// Reset clears both stages, the group state and the register; a new text
// starts. A stalled receiver holds the current item and, once the input
// stage backs up, raises in_stall.
module base32_strict_decoder_core
	import b32d_pkg::*;
#(
	parameter longint unsigned MAX_TEXT_CHARS = MAX_TEXT_CHARS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        char_code,
	input  logic              end_of_text,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        data_byte,
	output logic              byte_valid,
	output logic              done_res,
	output logic [2:0]        error_code,
	output logic [IDX_W-1:0]  error_index
);

	logic    hex_mode;
	logic    emit_ready;
	logic    push;
	bundle_t bundle;

	b32d_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.hex_mode     (hex_mode)
	);

	b32d_decode #(
		.MAX_TEXT_CHARS (MAX_TEXT_CHARS)
	) u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.hex_mode     (hex_mode),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.end_of_text  (end_of_text),
		.emit_ready   (emit_ready),
		.push         (push),
		.bundle       (bundle)
	);

	b32d_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.bundle      (bundle),
		.emit_ready  (emit_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_byte   (data_byte),
		.byte_valid  (byte_valid),
		.done_res    (done_res),
		.error_code  (error_code),
		.error_index (error_index)
	);

endmodule

@@ dv/b32d_stream_checker.sv @@
// Result checker for the strict base32 decoder: predicts each transfer's results and compares.
`timescale 1ns / 1ps

module b32d_stream_checker
	import b32d_pkg::*;
#(
	parameter longint unsigned TEXT_LIMIT = MAX_TEXT_CHARS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [7:0]        char_code,
	input  logic              end_of_text,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [7:0]        data_byte,
	input  logic              byte_valid,
	input  logic              done_res,
	input  logic [2:0]        error_code,
	input  logic [IDX_W-1:0]  error_index,
	output int                fail_count,
	output int                pending
);

	typedef struct {
		bit              hit;
		err_code_t       code;
		longint unsigned at;
	} fault_t;

	typedef struct {
		bit [7:0]       data;
		bit             is_byte;
		bit             is_done;
		err_code_t      code;
		bit [IDX_W-1:0] idx;
	} result_t;

	localparam bit [3:0] NO_PAD_SLOT = 4'd8;

	// Decoder copy: alphabet select, group and text state
	bit              hex_sel;
	bit [39:0]       grp_bits;
	bit [2:0]        grp_pos;
	bit [3:0]        pad_slot;
	longint unsigned text_pos;
	fault_t          full_fault;
	fault_t          short_fault;
	fault_t          text_fault;

	result_t due_results[$];
	result_t want;
	int      fails = 0;

	assign fail_count = fails;

	// Map a character to its 5-bit value; bit 5 flags membership
	function automatic bit [5:0] symbol_value(bit [7:0] c, bit hex);
		if (hex) begin
			if (c >= 8'h30 && c <= 8'h39) return {1'b1, 5'(c - 8'h30)};
			// 'A' stands for ten
			if (c >= 8'h41 && c <= 8'h56) return {1'b1, 5'(c - 8'h37)};
		end else begin
			if (c >= 8'h41 && c <= 8'h5A) return {1'b1, 5'(c - 8'h41)};
			// '2' stands for twenty-six
			if (c >= 8'h32 && c <= 8'h37) return {1'b1, 5'(c - 8'h18)};
		end
		return 6'd0;
	endfunction

	// Keep the first fault only
	function automatic fault_t first_fault(fault_t f, err_code_t code, longint unsigned at);
		fault_t r;
		r = f;
		if (!f.hit) r = '{hit: 1'b1, code: code, at: at};
		return r;
	endfunction

	function automatic void clear_group();
		grp_bits       = '0;
		grp_pos        = '0;
		pad_slot       = NO_PAD_SLOT;
		full_fault.hit  = 1'b0;
		short_fault.hit = 1'b0;
	endfunction

	// Queue the top bytes of a 40-bit group, most significant first
	function automatic void push_bytes(bit [39:0] bits, int count);
		for (int i = 0; i < count; i++) begin
			due_results.push_back('{data: bits[39-8*i -: 8], is_byte: 1'b1, is_done: 1'b0,
				code: ERR_OK, idx: '0});
		end
	endfunction

	// Advance the decoder copy by one character and queue what it yields
	task automatic decode_char(input bit [7:0] c, input bit eot);
		longint unsigned at;
		longint unsigned pad_at;
		bit [2:0]        pos;
		bit [5:0]        sym;
		bit              closed;
		bit [2:0]        dc;
		int              nbytes;
		int              pb;
		closed = 1'b0;
		if (!text_fault.hit) begin
			at = text_pos;
			if (at >= TEXT_LIMIT) begin
				text_fault = first_fault(text_fault, ERR_LENGTH, TEXT_LIMIT);
			end else begin
				pos      = grp_pos;
				sym      = symbol_value(c, hex_sel);
				text_pos = at + 1;
				if (c == PAD_CHAR) begin
					if (pad_slot == NO_PAD_SLOT) pad_slot = {1'b0, pos};
					short_fault = first_fault(short_fault, ERR_PAD_SHORT, at);
				end else if (!sym[5]) begin
					full_fault  = first_fault(full_fault, ERR_INVALID_CHAR, at);
					short_fault = first_fault(short_fault, ERR_INVALID_CHAR, at);
				end else if (pad_slot != NO_PAD_SLOT) begin
					full_fault = first_fault(full_fault, ERR_DATA_AFTER, at);
				end else begin
					grp_bits = {grp_bits[34:0], sym[4:0]};
				end
				// Close the group on its eighth character
				if (pos == 3'd7) begin
					pad_at = at - 7 + pad_slot;
					closed = 1'b1;
					if (full_fault.hit) begin
						text_fault = full_fault;
					end else if (pad_slot == NO_PAD_SLOT) begin
						push_bytes(grp_bits, 5);
					end else if (!eot) begin
						text_fault = first_fault(text_fault, ERR_PAD_NOT_LAST, pad_at);
					end else begin
						dc = pad_slot[2:0];
						case (dc)
							3'd2:    nbytes = 1;
							3'd4:    nbytes = 2;
							3'd5:    nbytes = 3;
							3'd7:    nbytes = 4;
							default: nbytes = 0;
						endcase
						if (nbytes == 0) begin
							text_fault = first_fault(text_fault, ERR_BAD_SHAPE, pad_at);
						end else begin
							pb = 5 * dc - 8 * nbytes;
							if ((grp_bits & ((40'd1 << pb) - 40'd1)) != 0) begin
								text_fault = first_fault(text_fault, ERR_PAD_BITS, pad_at - 1);
							end else begin
								push_bytes(grp_bits << (5 * (8 - dc)), nbytes);
							end
						end
					end
					clear_group();
				end else begin
					grp_pos = pos + 3'd1;
				end
				// Text ends inside a group
				if (eot && !closed && !text_fault.hit) begin
					if (short_fault.hit) text_fault = short_fault;
					else text_fault = first_fault(text_fault, ERR_LENGTH, at + 1);
				end
			end
		end
		// End mark: queue the status and start a fresh text
		if (eot) begin
			if (text_fault.hit) begin
				due_results.push_back('{data: 8'd0, is_byte: 1'b0, is_done: 1'b1,
					code: text_fault.code, idx: IDX_W'(text_fault.at)});
			end else begin
				due_results.push_back('{data: 8'd0, is_byte: 1'b0, is_done: 1'b1,
					code: ERR_OK, idx: '0});
			end
			text_pos       = 0;
			text_fault.hit = 1'b0;
			clear_group();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_sel        = 1'b0;
			text_pos       = 0;
			text_fault.hit = 1'b0;
			clear_group();
			due_results.delete();
			pending <= 0;
		end else begin
			// Track register writes
			if (psel && penable && pwrite && pready && paddr[2] == REG_HEX_MODE) begin
				hex_sel = pwdata[0];
			end
			// Compare each output transfer with the oldest prediction
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$error("unexpected result: data_byte %0h byte_valid %0b done_res %0b",
						data_byte, byte_valid, done_res);
					fails++;
				end else begin
					want = due_results.pop_front();
					if (data_byte !== want.data) begin
						$error("data_byte: expected %0h, got %0h", want.data, data_byte);
						fails++;
					end
					if (byte_valid !== want.is_byte) begin
						$error("byte_valid: expected %0b, got %0b", want.is_byte, byte_valid);
						fails++;
					end
					if (done_res !== want.is_done) begin
						$error("done_res: expected %0b, got %0b", want.is_done, done_res);
						fails++;
					end
					if (error_code !== want.code) begin
						$error("error_code: expected %0d, got %0d", want.code, error_code);
						fails++;
					end
					if (error_index !== want.idx) begin
						$error("error_index: expected %0d, got %0d", want.idx, error_index);
						fails++;
					end
				end
			end
			// Predict the results of each input transfer
			if (in_valid && !in_stall) decode_char(char_code, end_of_text);
			pending <= due_results.size();
		end
	end

endmodule

@@ dv/base32_strict_decoder_core_tb.sv @@
// Testbench top for the strict base32 decoder: clock, reset, text stimulus and verdict.
`timescale 1ns / 1ps

module base32_strict_decoder_core_tb;
	import b32d_pkg::*;

	// Short text limit so that over-long texts stay cheap
	localparam longint unsigned TEXT_LIMIT = 48;
	localparam int LONG_HOLD    = 300;
	localparam int WATCHDOG     = 5000;
	localparam int DRAIN_CYCLES = 4;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              psel        = 1'b0;
	logic              penable     = 1'b0;
	logic              pwrite      = 1'b0;
	logic [CFG_AW-1:0] paddr       = '0;
	logic [CFG_DW-1:0] pwdata      = '0;
	logic [CFG_DW-1:0] prdata;
	logic              pready;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [7:0]        char_code   = 8'd0;
	logic              end_of_text = 1'b0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [7:0]        data_byte;
	logic              byte_valid;
	logic              done_res;
	logic [2:0]        error_code;
	logic [IDX_W-1:0]  error_index;

	int fail_count;
	int pending;
	int send_idle_pct = 31;
	int recv_idle_pct = 60;
	bit long_hold     = 1'b0;
	bit hold_done     = 1'b0;
	bit hex_now       = 1'b0;
	int idle_cycles   = 0;

	bit [7:0] text_q[$];

	base32_strict_decoder_core #(
		.MAX_TEXT_CHARS(TEXT_LIMIT)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_byte   (data_byte),
		.byte_valid  (byte_valid),
		.done_res    (done_res),
		.error_code  (error_code),
		.error_index (error_index)
	);

	b32d_stream_checker #(
		.TEXT_LIMIT(TEXT_LIMIT)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_byte   (data_byte),
		.byte_valid  (byte_valid),
		.done_res    (done_res),
		.error_code  (error_code),
		.error_index (error_index),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold && !hold_done) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Drop the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic bit [7:0] alphabet_char(bit [4:0] v);
		if (hex_now) return (v < 5'd10) ? 8'h30 + 8'(v) : 8'h41 + 8'(v) - 8'd10;
		return (v < 5'd26) ? 8'h41 + 8'(v) : 8'h32 + 8'(v) - 8'd26;
	endfunction

	task automatic write_alphabet(input bit hex);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_AW'(4 * REG_HEX_MODE);
		pwdata  <= CFG_DW'(hex);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		hex_now = hex;
	endtask

	// Offer one character, with random idle cycles ahead of it
	task automatic send_char(input bit [7:0] c, input bit eot);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		char_code   <= c;
		end_of_text <= eot;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
	endtask

	task automatic send_text();
		foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
	endtask

	// Hold the sender until every predicted result has left the block
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_symbols(input int n);
		repeat (n) text_q.push_back(alphabet_char(5'($urandom_range(31))));
	endtask

	// Final group: dc data characters then pads; dirty sets a nonzero pad bit
	task automatic add_tail(input int dc, input bit dirty);
		bit [4:0] v;
		int       pb;
		pb = (5 * dc) % 8;
		for (int i = 0; i < dc; i++) begin
			v = 5'($urandom_range(31));
			if (i == dc - 1) begin
				if (dirty) v[0] = 1'b1;
				else v = v & ~5'((1 << pb) - 1);
			end
			text_q.push_back(alphabet_char(v));
		end
		repeat (8 - dc) text_q.push_back(PAD_CHAR);
	endtask

	function automatic int good_shape();
		case ($urandom_range(3))
			0:       return 2;
			1:       return 4;
			2:       return 5;
			default: return 7;
		endcase
	endfunction

	function automatic int bad_shape();
		case ($urandom_range(3))
			0:       return 0;
			1:       return 1;
			2:       return 3;
			default: return 6;
		endcase
	endfunction

	// Build one text: mostly well formed, some broken, some noise
	task automatic build_text();
		int kind;
		int groups;
		int pos;
		int cut;
		text_q.delete();
		kind   = $urandom_range(99);
		groups = (kind < 5) ? 7 : $urandom_range(0, 4);
		if (kind < 92) add_symbols(8 * groups);
		if (kind >= 5 && kind < 60) begin
			if ($urandom_range(9) < 6) add_tail(good_shape(), 1'b0);
			else if (groups == 0) add_symbols(8);
		end else if (kind >= 60 && kind < 68) begin
			add_tail(bad_shape(), 1'b0);
		end else if (kind >= 68 && kind < 76) begin
			add_tail(good_shape(), 1'b1);
		end else if (kind >= 76 && kind < 83) begin
			// padded group followed by more text
			add_tail(good_shape(), 1'b0);
			add_symbols(8);
		end else if (kind >= 83 && kind < 92) begin
			add_tail(good_shape(), 1'b0);
			pos = $urandom_range(text_q.size() - 1);
			case ($urandom_range(2))
				0:       text_q[pos] = 8'($urandom_range(255));
				1:       text_q[pos] = PAD_CHAR;
				default: text_q[pos] = alphabet_char(5'($urandom_range(31)));
			endcase
			if ($urandom_range(2) == 0) begin
				cut = $urandom_range(1, 3);
				repeat (cut) if (text_q.size() > 1) void'(text_q.pop_back());
			end
		end else if (kind >= 92) begin
			repeat ($urandom_range(1, 12)) begin
				case ($urandom_range(5))
					0, 1:    text_q.push_back(alphabet_char(5'($urandom_range(31))));
					2:       text_q.push_back(PAD_CHAR);
					default: text_q.push_back(8'($urandom_range(255)));
				endcase
			end
		end
	endtask

	task automatic run_texts(input int n_chars);
		int sent;
		sent = 0;
		while (sent < n_chars) begin
			build_text();
			sent += text_q.size();
			send_text();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed texts, standard alphabet from reset
		send_string("MZXW6===");
		send_string("A=B=====");
		send_char(8'hFF, 1'b1);
		send_char(PAD_CHAR, 1'b1);
		send_string("2Z7");
		send_char(8'h00, 1'b1);
		drain();
		write_alphabet(1'b1);
		send_string("CPNMU===");

		// Sender lightly idle, receiver heavily stalled
		run_texts(110);
		drain();
		write_alphabet(1'b0);

		// Sender heavily idle, receiver lightly stalled
		send_idle_pct = 60;
		recv_idle_pct = 31;
		run_texts(110);
		drain();
		write_alphabet(1'b1);

		// No idling; open with a long receiver hold-off to back up the input
		send_idle_pct = 0;
		recv_idle_pct = 0;
		long_hold = 1'b1;
		run_texts(60);
		drain();
		write_alphabet(1'b0);
		run_texts(60);
		drain();

		if (fail_count == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/b32d_pkg.sv
hdl/b32d_cfg.sv
hdl/b32d_decode.sv
hdl/b32d_emit.sv
hdl/base32_strict_decoder_core.sv
dv/b32d_stream_checker.sv
dv/base32_strict_decoder_core_tb.sv
